[rtl/vcf_pkg.sv]
// ----------------------------------------------------------------------------
// vcf_pkg
// Shared format codes, constants and types for the vertex component decoder.
// ----------------------------------------------------------------------------
package vcf_pkg;

    localparam logic [3:0] FMT_F32     = 4'd0;
    localparam logic [3:0] FMT_F16     = 4'd1;
    localparam logic [3:0] FMT_UNORM8  = 4'd2;
    localparam logic [3:0] FMT_SNORM8  = 4'd3;
    localparam logic [3:0] FMT_UNORM16 = 4'd4;
    localparam logic [3:0] FMT_SNORM16 = 4'd5;
    localparam logic [3:0] FMT_U8      = 4'd6;
    localparam logic [3:0] FMT_S8      = 4'd7;
    localparam logic [3:0] FMT_U16     = 4'd8;
    localparam logic [3:0] FMT_S16     = 4'd9;
    localparam logic [3:0] FMT_U32     = 4'd10;
    localparam logic [3:0] FMT_S32     = 4'd11;

    localparam int MagW = 64;
    localparam int FracW = 56;

    localparam logic [7:0] BiasInt  = 8'd127;
    localparam logic [7:0] BiasNorm = 8'(127 - FracW);
    localparam logic [7:0] HalfRebias = 8'd112;

    typedef struct packed {
        logic            direct;
        logic [31:0]     direct_bits;
        logic            sign;
        logic [MagW-1:0] mag;
        logic [7:0]      exp_base;
        logic            sticky_in;
    } t_conv;

    function automatic logic [2:0] size_of_code(input logic [3:0] code);
        logic [2:0] sz;
        case (code) inside
            FMT_F32, FMT_U32, FMT_S32: sz = 3'd4;
            FMT_F16, FMT_UNORM16, FMT_SNORM16, FMT_U16, FMT_S16: sz = 3'd2;
            FMT_UNORM8, FMT_SNORM8, FMT_U8, FMT_S8: sz = 3'd1;
            default: sz = 3'd0;
        endcase
        return sz;
    endfunction

endpackage

[rtl/vcf_decode.sv]
// ----------------------------------------------------------------------------
// vcf_decode
// Per-format setup: direct bit patterns for f32/f16/unsupported codes, and a
// fixed-point magnitude with exponent base for the converted formats.
// ----------------------------------------------------------------------------
module vcf_decode (
    input  logic [3:0]   i_format_code,
    input  logic [31:0]  i_raw_bytes,
    output vcf_pkg::t_conv o_conv,
    output logic [2:0]   o_component_bytes,
    output logic         o_format_handled
);

    localparam logic [vcf_pkg::MagW-1:0] SnormMin = 64'h0102040810204080;

    logic [7:0]              b0;
    logic [15:0]             w0;
    logic [7:0]              smag;
    logic [vcf_pkg::MagW-1:0] snorm_acc;
    logic [4:0]              hex;
    logic [31:0]             half_bits;

    assign b0   = i_raw_bytes[7:0];
    assign w0   = i_raw_bytes[15:0];
    assign smag = b0[7] ? 8'(~b0 + 8'd1) : b0;
    assign hex  = w0[14:10];

    always_comb begin
        if (hex == 5'd0) begin
            half_bits = {w0[15], 31'd0};
        end else if (hex == 5'h1f) begin
            half_bits = {w0[15], 8'hff, w0[9:0], 13'd0};
        end else begin
            half_bits = {w0[15], 8'({3'd0, hex} + vcf_pkg::HalfRebias), w0[9:0], 13'd0};
        end
    end

    // repeat the 7-bit magnitude; only 128 spills past seven bits
    assign snorm_acc = smag[7] ? SnormMin : {8'd0, {8{smag[6:0]}}};

    always_comb begin
        o_conv = '0;
        case (i_format_code)
            vcf_pkg::FMT_F32: begin
                o_conv.direct      = 1'b1;
                o_conv.direct_bits = i_raw_bytes;
            end
            vcf_pkg::FMT_F16: begin
                o_conv.direct      = 1'b1;
                o_conv.direct_bits = half_bits;
            end
            vcf_pkg::FMT_UNORM8: begin
                o_conv.mag       = {8'd0, b0, b0, b0, b0, b0, b0, b0};
                o_conv.exp_base  = vcf_pkg::BiasNorm;
                o_conv.sticky_in = 1'b1;
            end
            vcf_pkg::FMT_SNORM8: begin
                o_conv.sign      = b0[7];
                o_conv.mag       = snorm_acc;
                o_conv.exp_base  = vcf_pkg::BiasNorm;
                o_conv.sticky_in = 1'b1;
            end
            vcf_pkg::FMT_UNORM16: begin
                o_conv.mag       = {8'd0, w0, w0, w0, 8'd0};
                o_conv.exp_base  = vcf_pkg::BiasNorm;
                o_conv.sticky_in = 1'b1;
            end
            vcf_pkg::FMT_U8: begin
                o_conv.mag      = vcf_pkg::MagW'(b0);
                o_conv.exp_base = vcf_pkg::BiasInt;
            end
            vcf_pkg::FMT_U16: begin
                o_conv.mag      = vcf_pkg::MagW'(w0);
                o_conv.exp_base = vcf_pkg::BiasInt;
            end
            vcf_pkg::FMT_U32: begin
                o_conv.mag      = vcf_pkg::MagW'(i_raw_bytes);
                o_conv.exp_base = vcf_pkg::BiasInt;
            end
            default: begin
                o_conv.direct      = 1'b1;
                o_conv.direct_bits = 32'd0;
            end
        endcase
    end

    assign o_component_bytes = vcf_pkg::size_of_code(i_format_code);

    always_comb begin
        case (i_format_code) inside
            vcf_pkg::FMT_F32, vcf_pkg::FMT_F16, vcf_pkg::FMT_UNORM8, vcf_pkg::FMT_SNORM8,
            vcf_pkg::FMT_UNORM16, vcf_pkg::FMT_U8, vcf_pkg::FMT_U16,
            vcf_pkg::FMT_U32: o_format_handled = 1'b1;
            default:          o_format_handled = 1'b0;
        endcase
    end

endmodule

[rtl/vcf_round.sv]
// ----------------------------------------------------------------------------
// vcf_round
// Normalize a fixed-point magnitude and round to single precision, nearest
// even; direct patterns pass unchanged.
// ----------------------------------------------------------------------------
module vcf_round (
    input  vcf_pkg::t_conv i_conv,
    output logic [31:0]    o_value_bits
);

    logic [5:0]               msb;
    logic [vcf_pkg::MagW-1:0] sh;
    logic [22:0]              mant;
    logic                     guard;
    logic                     sticky;
    logic                     up;
    logic [23:0]              mant_r;
    logic [7:0]               ex;

    always_comb begin
        msb = '0;
        for (int i = 0; i < vcf_pkg::MagW; i++) begin
            if (i_conv.mag[i]) begin
                msb = 6'(i);
            end
        end
    end

    assign sh     = i_conv.mag << (6'(vcf_pkg::MagW - 1) - msb);
    assign mant   = sh[62:40];
    assign guard  = sh[39];
    assign sticky = (|sh[38:0]) | i_conv.sticky_in;
    assign up     = guard & (sticky | mant[0]);
    assign mant_r = {1'b0, mant} + 24'(up);
    assign ex     = i_conv.exp_base + {2'd0, msb} + {7'd0, mant_r[23]};

    always_comb begin
        if (i_conv.direct) begin
            o_value_bits = i_conv.direct_bits;
        end else if (i_conv.mag == '0) begin
            o_value_bits = 32'd0;
        end else begin
            o_value_bits = {i_conv.sign, ex, mant_r[22:0]};
        end
    end

endmodule

[rtl/vertex_component_to_float32_core.sv]
// ----------------------------------------------------------------------------
// vertex_component_to_float32_core
// An accepted start sets r_in_vld, which in turn sets r_out_vld, the o_valid strobe.
// Throughput: one component per cycle; busy stays low, input and result
// registers are set by a single decode-and-round stage between them.
// Reset: synchronous active-low i_rst_n clears both valid flags.
// ----------------------------------------------------------------------------
module vertex_component_to_float32_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_format_code,
    input  logic [31:0] i_raw_bytes,
    output logic        o_valid,
    output logic [31:0] o_value_bits,
    output logic [2:0]  o_component_bytes,
    output logic        o_format_handled
);

    logic           r_in_vld, n_in_vld;
    logic [3:0]     r_code;
    logic [31:0]    r_raw;
    logic           r_out_vld;
    logic [31:0]    r_value;
    logic [2:0]     r_bytes;
    logic           r_handled;

    vcf_pkg::t_conv conv;
    logic [31:0]    value;
    logic [2:0]     bytes;
    logic           handled;

    assign busy     = 1'b0;
    assign n_in_vld = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_in_vld) begin
            r_code <= i_format_code;
            r_raw  <= i_raw_bytes;
        end
        if (r_in_vld) begin
            r_value   <= value;
            r_bytes   <= bytes;
            r_handled <= handled;
        end
    end

    vcf_decode u_decode (
        .i_format_code     (r_code),
        .i_raw_bytes       (r_raw),
        .o_conv            (conv),
        .o_component_bytes (bytes),
        .o_format_handled  (handled)
    );

    vcf_round u_round (
        .i_conv       (conv),
        .o_value_bits (value)
    );

    assign o_valid           = r_out_vld;
    assign o_value_bits      = r_value;
    assign o_component_bytes = r_bytes;
    assign o_format_handled  = r_handled;

endmodule

[rtl/vcf_checker.sv]
// ----------------------------------------------------------------------------
// vcf_checker
// Port-level checks on beat timing and result consistency.
// ----------------------------------------------------------------------------
module vcf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [31:0] o_value_bits,
    input logic [2:0]  o_component_bytes,
    input logic        o_format_handled
);

    a_beat_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("accepted beat produced no result two cycles later");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 2))
        else $error("result without an accepted beat");

    a_unhandled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_format_handled) |-> (o_value_bits == 32'd0))
        else $error("unsupported format gave nonzero value");

    a_handled_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_format_handled) |->
        (o_component_bytes == 3'd1 || o_component_bytes == 3'd2 ||
         o_component_bytes == 3'd4))
        else $error("decoded format with bad component size");

endmodule

bind vertex_component_to_float32_core vcf_checker u_vcf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_valid           (o_valid),
    .o_value_bits      (o_value_bits),
    .o_component_bytes (o_component_bytes),
    .o_format_handled  (o_format_handled)
);

[tb/sv/tb_vertex_component_to_float32_core.sv]
// ----------------------------------------------------------------------------
// tb_vertex_component_to_float32_core
// Drives vertex attribute components through the decoder and checks every
// result beat against an exact integer-rounded single-precision predictor.
// ----------------------------------------------------------------------------
module tb_vertex_component_to_float32_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] FMT_RSVD_LO = 4'd12;
    localparam logic [3:0] FMT_RSVD_HI = 4'd15;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [31:0] value_bits;
        logic [2:0]  component_bytes;
        logic        format_handled;
    } t_component;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  i_format_code;
    logic [31:0] i_raw_bytes;
    logic        o_valid;
    logic [31:0] o_value_bits;
    logic [2:0]  o_component_bytes;
    logic        o_format_handled;

    t_component decoded_q[$];
    int         err_count;
    int         cycle_count;
    bit         quiet_sender;

    vertex_component_to_float32_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_format_code     (i_format_code),
        .i_raw_bytes       (i_raw_bytes),
        .o_valid           (o_valid),
        .o_value_bits      (o_value_bits),
        .o_component_bytes (o_component_bytes),
        .o_format_handled  (o_format_handled)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [31:0] ratio_to_float(input logic s, input logic [31:0] n,
                                                   input logic [16:0] d);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        logic [127:0] rest;
        logic [127:0] half;
        logic [24:0]  mant;
        int           p;
        int           sh;
        if (n == 32'd0) return {s, 31'd0};
        num = {96'd0, n} << 40;
        q = num / d;
        r = num % d;
        p = 0;
        for (int i = 0; i < 128; i++) if (q[i]) p = i;
        sh = p - 23;
        mant = 25'(q >> sh);
        rest = q & ((128'd1 << sh) - 128'd1);
        half = 128'd1 << (sh - 1);
        if (rest > half || (rest == half && (r != 0 || mant[0]))) mant = mant + 25'd1;
        if (mant[24]) begin
            mant = mant >> 1;
            p++;
        end
        return {s, 8'(p - 40 + 127), mant[22:0]};
    endfunction

    function automatic logic [31:0] widen_f16(input logic [15:0] h);
        if (h[14:10] == 5'd0) return {h[15], 31'd0};
        if (h[14:10] == 5'h1f) return {h[15], 8'hff, h[9:0], 13'd0};
        return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
    endfunction

    function automatic t_component decode_component(input logic [3:0] code,
                                                    input logic [31:0] raw);
        t_component c;
        c.component_bytes = 3'd0;
        c.format_handled = 1'b1;
        c.value_bits = 32'd0;
        case (code)
            vcf_pkg::FMT_F32: c.value_bits = raw;
            vcf_pkg::FMT_F16: c.value_bits = widen_f16(raw[15:0]);
            vcf_pkg::FMT_UNORM8:
                c.value_bits = ratio_to_float(1'b0, {24'd0, raw[7:0]}, 17'd255);
            vcf_pkg::FMT_SNORM8: c.value_bits = raw[7]
                ? ratio_to_float(1'b1, 32'd256 - {24'd0, raw[7:0]}, 17'd127)
                : ratio_to_float(1'b0, {24'd0, raw[7:0]}, 17'd127);
            vcf_pkg::FMT_UNORM16:
                c.value_bits = ratio_to_float(1'b0, {16'd0, raw[15:0]}, 17'd65535);
            vcf_pkg::FMT_U8:
                c.value_bits = ratio_to_float(1'b0, {24'd0, raw[7:0]}, 17'd1);
            vcf_pkg::FMT_U16:
                c.value_bits = ratio_to_float(1'b0, {16'd0, raw[15:0]}, 17'd1);
            vcf_pkg::FMT_U32: c.value_bits = ratio_to_float(1'b0, raw, 17'd1);
            default: c.format_handled = 1'b0;
        endcase
        case (code)
            vcf_pkg::FMT_F32, vcf_pkg::FMT_U32, vcf_pkg::FMT_S32:
                c.component_bytes = 3'd4;
            vcf_pkg::FMT_F16, vcf_pkg::FMT_UNORM16, vcf_pkg::FMT_SNORM16,
            vcf_pkg::FMT_U16, vcf_pkg::FMT_S16:
                c.component_bytes = 3'd2;
            vcf_pkg::FMT_UNORM8, vcf_pkg::FMT_SNORM8, vcf_pkg::FMT_U8, vcf_pkg::FMT_S8:
                c.component_bytes = 3'd1;
            default: c.component_bytes = 3'd0;
        endcase
        return c;
    endfunction

    task automatic send_component(input logic [3:0] code, input logic [31:0] raw);
        start <= 1'b1;
        i_format_code <= code;
        i_raw_bytes <= raw;
        do @(posedge i_clk); while (busy);
        decoded_q.insert(decoded_q.size(), decode_component(code, raw));
        if (!quiet_sender && $urandom_range(99) < 14) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_component exp_c;
        if (i_rst_n && o_valid) begin
            if (decoded_q.size() == 0) begin
                $error("result beat with no expectation, value_bits %h", o_value_bits);
                err_count++;
            end else begin
                exp_c = decoded_q.pop_front();
                if (o_value_bits !== exp_c.value_bits) begin
                    $error("value_bits expected %h actual %h", exp_c.value_bits, o_value_bits);
                    err_count++;
                end
                if (o_component_bytes !== exp_c.component_bytes) begin
                    $error("component_bytes expected %0d actual %0d",
                           exp_c.component_bytes, o_component_bytes);
                    err_count++;
                end
                if (o_format_handled !== exp_c.format_handled) begin
                    $error("format_handled expected %0d actual %0d",
                           exp_c.format_handled, o_format_handled);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_vertex_component_to_float32_core: errors");
            $finish;
        end
    end

    function automatic logic [31:0] random_raw(input logic [3:0] code);
        logic [31:0] raw;
        raw = $urandom;
        if (code == vcf_pkg::FMT_F16) begin
            case ($urandom_range(3))
                0: raw[14:10] = 5'd0;
                1: raw[14:10] = 5'h1f;
                default: ;
            endcase
        end
        if ($urandom_range(9) == 0) raw = $urandom_range(1) ? 32'hffffffff : 32'd0;
        return raw;
    endfunction

    task automatic test_directed();
        send_component(vcf_pkg::FMT_F32, 32'h00000000);
        send_component(vcf_pkg::FMT_F32, 32'hffffffff);
        send_component(vcf_pkg::FMT_F32, 32'h7fc00001);
        send_component(vcf_pkg::FMT_F16, 32'hffff8000);
        send_component(vcf_pkg::FMT_F16, 32'h00000001);
        send_component(vcf_pkg::FMT_F16, 32'h00007c00);
        send_component(vcf_pkg::FMT_F16, 32'h0000fc00);
        send_component(vcf_pkg::FMT_F16, 32'h00007e01);
        send_component(vcf_pkg::FMT_F16, 32'habcd3c00);
        send_component(vcf_pkg::FMT_F16, 32'h00007bff);
        send_component(vcf_pkg::FMT_UNORM8, 32'h000000ff);
        send_component(vcf_pkg::FMT_UNORM8, 32'hffffff80);
        send_component(vcf_pkg::FMT_SNORM8, 32'h00000080);
        send_component(vcf_pkg::FMT_SNORM8, 32'h0000007f);
        send_component(vcf_pkg::FMT_SNORM8, 32'hffffffff);
        send_component(vcf_pkg::FMT_UNORM16, 32'hffffffff);
        send_component(vcf_pkg::FMT_U8, 32'h000000ff);
        send_component(vcf_pkg::FMT_U16, 32'h0000ffff);
        send_component(vcf_pkg::FMT_U32, 32'hffffffff);
        send_component(vcf_pkg::FMT_U32, 32'h01000001);
        send_component(vcf_pkg::FMT_SNORM16, 32'hffffffff);
        send_component(vcf_pkg::FMT_S8, 32'h00000080);
        send_component(vcf_pkg::FMT_S16, 32'h00008000);
        send_component(vcf_pkg::FMT_S32, 32'h80000000);
        send_component(FMT_RSVD_LO, 32'hffffffff);
        send_component(FMT_RSVD_HI, 32'h12345678);
    endtask

    task automatic test_random(input int count);
        logic [3:0] code;
        for (int i = 0; i < count; i++) begin
            code = 4'($urandom_range(15));
            send_component(code, random_raw(code));
        end
    endtask

    initial begin
        err_count = 0;
        cycle_count = 0;
        quiet_sender = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_format_code = vcf_pkg::FMT_F32;
        i_raw_bytes = 32'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_drained();
        test_random(400);
        wait_drained();
        quiet_sender = 1'b1;
        test_random(200);
        quiet_sender = 1'b0;
        test_random(400);
        wait_drained();

        if (err_count == 0) begin
            $display("tb_vertex_component_to_float32_core: clean");
        end else begin
            $display("tb_vertex_component_to_float32_core: errors");
        end
        $finish;
    end

endmodule
